// ----- src/aprm_pkg.sv -----
// ----------------------------------------------------------------------------
// aprm_pkg
// shared widths, constants, sequencer states and divider control types
// ----------------------------------------------------------------------------
package aprm_pkg;

  localparam int TIME_W     = 48;
  localparam int TOTAL_W    = 56;
  localparam int CNT_W      = 7;
  localparam int TPS_W      = 32;
  localparam int PRESS_W    = 32;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  // shared divider: dividend as wide as the total, divisor as wide as a time
  localparam int DIV_N_W    = TOTAL_W;
  localparam int DIV_D_W    = TIME_W;
  localparam int DIV_STEPS  = DIV_N_W;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

  localparam logic [TPS_W-1:0] TPS_RESET   = TPS_W'(1000000000);
  localparam logic [CNT_W-1:0] COUNT_LIMIT = CNT_W'(100);
  localparam logic [CNT_W-1:0] COUNT_KEEP  = CNT_W'(20);

  // last button codes
  localparam logic [1:0] BTN_NONE = 2'd0;
  localparam logic [1:0] BTN_ONE  = 2'd1;
  localparam logic [1:0] BTN_TWO  = 2'd2;

  // register index carried by paddr[2]
  localparam logic REG_TPS = 1'b0;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MEAN_GO,
    S_MEAN_WAIT,
    S_MUL,
    S_SPEED_GO,
    S_SPEED_WAIT,
    S_DONE
  } seq_state_t;

  typedef struct packed {
    logic                 start;
    logic [DIV_N_W-1:0]   dividend;
    logic [DIV_D_W-1:0]   divisor;
  } div_req_t;

  typedef struct packed {
    logic                 busy;
    logic                 done;
    logic [DIV_N_W-1:0]   quotient;
  } div_rsp_t;

endpackage

// ----- src/aprm_in_if.sv -----
// ----------------------------------------------------------------------------
// aprm_in_if
// press channel: button kind and timestamp with valid/ready
// ----------------------------------------------------------------------------
interface aprm_in_if;
  logic                        valid;
  logic                        ready;
  logic                        kind;
  logic [aprm_pkg::TIME_W-1:0] press_time;

  modport source (output valid, output kind, output press_time, input ready);
  modport sink   (input valid, input kind, input press_time, output ready);
endinterface

// ----- src/aprm_out_if.sv -----
// ----------------------------------------------------------------------------
// aprm_out_if
// result channel: average, speed and counters with valid/ready
// ----------------------------------------------------------------------------
interface aprm_out_if;
  logic                         valid;
  logic                         ready;
  logic [aprm_pkg::TIME_W-1:0]  average_interval;
  logic [aprm_pkg::TPS_W-1:0]   press_speed;
  logic [aprm_pkg::CNT_W-1:0]   alternating_count;
  logic [aprm_pkg::PRESS_W-1:0] total_presses;
  logic                         counted;

  modport source (output valid, output average_interval, output press_speed,
                  output alternating_count, output total_presses, output counted,
                  input ready);
  modport sink   (input valid, input average_interval, input press_speed,
                  input alternating_count, input total_presses, input counted,
                  output ready);
endinterface

// ----- src/aprm_div.sv -----
// ----------------------------------------------------------------------------
// aprm_div
// restoring unsigned divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module aprm_div (
  input  logic               clk,
  input  logic               rst_n,
  input  aprm_pkg::div_req_t req,
  output aprm_pkg::div_rsp_t rsp
);
  import aprm_pkg::*;

  logic [DIV_N_W-1:0]   quo_r, quo_nxt;
  logic [DIV_D_W-1:0]   rem_r, rem_nxt;
  logic [DIV_D_W-1:0]   dsr_r, dsr_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [DIV_D_W:0]     trial;
  logic [DIV_D_W:0]     diff;

  assign trial = {rem_r, quo_r[DIV_N_W-1]};
  assign diff  = trial - {1'b0, dsr_r};

  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      quo_nxt  = req.dividend;
      rem_nxt  = '0;
      dsr_nxt  = req.divisor;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // no borrow means the trial remainder covers the divisor
      if (!diff[DIV_D_W]) begin
        rem_nxt = diff[DIV_D_W-1:0];
        quo_nxt = {quo_r[DIV_N_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[DIV_D_W-1:0];
        quo_nxt = {quo_r[DIV_N_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == DIV_CNT_W'(DIV_STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
  end

  assign rsp.busy     = busy_r;
  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule

// ----- src/aprm_cfg.sv -----
// ----------------------------------------------------------------------------
// aprm_cfg
// apb register file holding ticks per second
// ----------------------------------------------------------------------------
module aprm_cfg (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [aprm_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [aprm_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [aprm_pkg::CFG_DATA_W-1:0] prdata,
  output logic                            pready,
  output logic [aprm_pkg::TPS_W-1:0]      tps
);
  import aprm_pkg::*;

  logic [TPS_W-1:0] tps_r;
  logic             wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tps_r <= TPS_RESET;
    end else if (wr_en && paddr[2] == REG_TPS) begin
      tps_r <= pwdata[TPS_W-1:0];
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_TPS: prdata = CFG_DATA_W'(tps_r);
      default: prdata = '0;
    endcase
  end

  assign tps = tps_r;

endmodule

// ----- src/alternating_press_rate_meter_core.sv -----
// ----------------------------------------------------------------------------
// alternating_press_rate_meter_core
// alternating two-button press rate meter with apb configuration
// ----------------------------------------------------------------------------
// One result transaction per press transaction. A press of the button other
// than the last one adds the wrapped interval to a running total; the mean is
// the total over the count and the speed is ticks per second over the mean.
// Both quotients come from one shared restoring divider that retires one bit
// per cycle over 56 steps. The input takes a new press once the sequencer is
// idle again: a counted press runs the mean division, the multiply and the
// speed division, one that does not alternate only the speed division; while
// the mean is zero the speed division is skipped. A result that still waits in
// a stalled output register when the next one is finished adds that stall. The
// input channel is ready only while the sequencer is idle; a finished result
// sits in the output register so the next press can be taken while it waits.
module alternating_press_rate_meter_core (
  input  logic                            clk,
  input  logic                            rst_n,
  aprm_in_if.sink                         in_ch,
  aprm_out_if.source                      out_ch,
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [aprm_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [aprm_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic [aprm_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                            cfg_pready
);
  import aprm_pkg::*;

  seq_state_t state_r, state_nxt;

  // meter state
  logic [1:0]         prev_btn_r, prev_btn_nxt;
  logic [TIME_W-1:0]  prev_time_r, prev_time_nxt;
  logic [TOTAL_W-1:0] total_r, total_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [TIME_W-1:0]  mean_r, mean_nxt;
  logic [PRESS_W-1:0] presses_r, presses_nxt;

  // per press working values
  logic               counted_r, counted_nxt;
  logic [TPS_W-1:0]   speed_r, speed_nxt;

  // output register
  logic               ovalid_r, ovalid_nxt;
  logic [TIME_W-1:0]  oavg_r, oavg_nxt;
  logic [TPS_W-1:0]   ospeed_r, ospeed_nxt;
  logic [CNT_W-1:0]   ocount_r, ocount_nxt;
  logic [PRESS_W-1:0] opress_r, opress_nxt;
  logic               ocounted_r, ocounted_nxt;

  logic [TPS_W-1:0]   tps;
  div_req_t           div_req;
  div_rsp_t           div_rsp;

  logic               in_acc;
  logic [1:0]         button;
  logic [1:0]         other;
  logic [TIME_W-1:0]  gap;
  logic [CNT_W-1:0]   mul_op;
  logic [TOTAL_W-1:0] product;

  aprm_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .tps     (tps)
  );

  aprm_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;

  // kind 0 is button one, kind 1 button two
  assign button = in_ch.kind ? BTN_TWO : BTN_ONE;
  assign other  = in_ch.kind ? BTN_ONE : BTN_TWO;
  // wraps naturally at the timestamp width
  assign gap    = in_ch.press_time - prev_time_r;

  // count above the limit folds back to the kept count, in the same multiply
  assign mul_op  = (count_r > COUNT_LIMIT) ? COUNT_KEEP : count_r;
  assign product = TOTAL_W'(mean_r) * TOTAL_W'(mul_op);

  always_comb begin
    state_nxt     = state_r;
    prev_btn_nxt  = prev_btn_r;
    prev_time_nxt = prev_time_r;
    total_nxt     = total_r;
    count_nxt     = count_r;
    mean_nxt      = mean_r;
    presses_nxt   = presses_r;
    counted_nxt   = counted_r;
    speed_nxt     = speed_r;
    ovalid_nxt    = ovalid_r;
    oavg_nxt      = oavg_r;
    ospeed_nxt    = ospeed_r;
    ocount_nxt    = ocount_r;
    opress_nxt    = opress_r;
    ocounted_nxt  = ocounted_r;
    div_req       = '0;

    // output register drains independently of the sequencer
    if (ovalid_r && out_ch.ready) begin
      ovalid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          prev_btn_nxt  = button;
          prev_time_nxt = in_ch.press_time;
          presses_nxt   = presses_r + 1'b1;
          counted_nxt   = (prev_btn_r == other);
          if (prev_btn_r == other) begin
            total_nxt = total_r + TOTAL_W'(gap);
            count_nxt = count_r + 1'b1;
            state_nxt = S_MEAN_GO;
          end else begin
            state_nxt = S_SPEED_GO;
          end
        end
      end
      S_MEAN_GO: begin
        div_req.start    = 1'b1;
        div_req.dividend = total_r;
        div_req.divisor  = DIV_D_W'(count_r);
        state_nxt        = S_MEAN_WAIT;
      end
      S_MEAN_WAIT: begin
        if (div_rsp.done) begin
          mean_nxt  = div_rsp.quotient[TIME_W-1:0];
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        // rebuild the total from the truncated mean
        total_nxt = product;
        count_nxt = mul_op;
        state_nxt = S_SPEED_GO;
      end
      S_SPEED_GO: begin
        if (mean_r == '0) begin
          speed_nxt = '0;
          state_nxt = S_DONE;
        end else begin
          div_req.start    = 1'b1;
          div_req.dividend = DIV_N_W'(tps);
          div_req.divisor  = mean_r;
          state_nxt        = S_SPEED_WAIT;
        end
      end
      S_SPEED_WAIT: begin
        if (div_rsp.done) begin
          // ticks per second fits 32 bits, so does the quotient
          speed_nxt = div_rsp.quotient[TPS_W-1:0];
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        // wait for a free output register
        if (!ovalid_r || out_ch.ready) begin
          ovalid_nxt   = 1'b1;
          oavg_nxt     = mean_r;
          ospeed_nxt   = speed_r;
          ocount_nxt   = count_r;
          opress_nxt   = presses_r;
          ocounted_nxt = counted_r;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_btn_r  <= BTN_NONE;
      prev_time_r <= '0;
      total_r     <= '0;
      count_r     <= '0;
      mean_r      <= '0;
      presses_r   <= '0;
      ovalid_r    <= 1'b0;
    end else begin
      prev_btn_r  <= prev_btn_nxt;
      prev_time_r <= prev_time_nxt;
      total_r     <= total_nxt;
      count_r     <= count_nxt;
      mean_r      <= mean_nxt;
      presses_r   <= presses_nxt;
      ovalid_r    <= ovalid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    counted_r  <= counted_nxt;
    speed_r    <= speed_nxt;
    oavg_r     <= oavg_nxt;
    ospeed_r   <= ospeed_nxt;
    ocount_r   <= ocount_nxt;
    opress_r   <= opress_nxt;
    ocounted_r <= ocounted_nxt;
  end

  assign out_ch.valid             = ovalid_r;
  assign out_ch.average_interval  = oavg_r;
  assign out_ch.press_speed       = ospeed_r;
  assign out_ch.alternating_count = ocount_r;
  assign out_ch.total_presses     = opress_r;
  assign out_ch.counted           = ocounted_r;

endmodule

// ----- src/aprm_checker.sv -----
// ----------------------------------------------------------------------------
// aprm_checker
// port level checks on the rate meter, bound to the top level
// ----------------------------------------------------------------------------
module aprm_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [aprm_pkg::TIME_W-1:0]  average_interval,
  input logic [aprm_pkg::TPS_W-1:0]   press_speed,
  input logic [aprm_pkg::CNT_W-1:0]   alternating_count,
  input logic [aprm_pkg::PRESS_W-1:0] total_presses,
  input logic                         counted
);
  import aprm_pkg::*;

  // a press keeps the sequencer busy for at least the next cycle
  a_busy_after_press: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready straight after a press transaction");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(average_interval)
      && $stable(press_speed) && $stable(total_presses))
    else $error("stalled result transaction changed");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> alternating_count <= COUNT_LIMIT && (!counted || alternating_count != '0))
    else $error("alternating count out of range");

  a_zero_mean_speed: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && average_interval == '0 |-> press_speed == '0)
    else $error("speed reported with a zero mean");

endmodule

bind alternating_press_rate_meter_core aprm_checker u_aprm_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_ch.valid),
  .in_ready          (in_ch.ready),
  .out_valid         (out_ch.valid),
  .out_ready         (out_ch.ready),
  .average_interval  (out_ch.average_interval),
  .press_speed       (out_ch.press_speed),
  .alternating_count (out_ch.alternating_count),
  .total_presses     (out_ch.total_presses),
  .counted           (out_ch.counted)
);
